FILE: hdl/eac_pkg.sv
`default_nettype none

package eac_pkg;

  // Frame identifiers and steering commands
  localparam logic [28:0] ID_RPM   = 29'd218099784;
  localparam logic [28:0] ID_TEMP  = 29'd218101064;
  localparam logic [28:0] ID_STEER = 29'd0;
  localparam logic [7:0]  CMD_UP   = 8'd10;
  localparam logic [7:0]  CMD_DOWN = 8'd11;

  // Item kinds
  localparam logic ACTION_FRAME = 1'b0;
  localparam logic ACTION_TICK  = 1'b1;

  // Shift timing in ticks
  localparam logic [4:0] SPARK_CUT_TICKS = 5'd10;
  localparam logic [4:0] SOLENOID_TICKS  = 5'd20;

  // Status pulse
  localparam logic [3:0] STATUS_PERIOD = 4'd10;
  localparam logic [3:0] MSG_TIMER_MAX = 4'd15;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PUMP_ON_RPM   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAN_ON_TEMP   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAN_OFF_TEMP  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAN_MIN_RPM   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAN_CUT_RPM   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_FUEL_CUT_RPM  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENGINE_OFF_MS = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_AFTERRUN_MS   = 3'd7;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CUT  = 2'd1,
    PH_HOLD = 2'd2
  } shift_phase_t;

  typedef struct packed {
    logic [15:0]        pump_on_rpm;
    logic signed [15:0] fan_on_temp;
    logic signed [15:0] fan_off_temp;
    logic [15:0]        fan_min_rpm;
    logic [15:0]        fan_cut_rpm;
    logic [15:0]        fuel_cut_rpm;
    logic [15:0]        engine_off_ms;
    logic [15:0]        afterrun_ms;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [28:0] frame_id;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte1;
    logic [7:0]  data_byte4;
    logic [7:0]  data_byte5;
    logic        neutral_level;
  } item_t;

  typedef struct packed {
    logic [15:0]        engine_rpm;
    logic signed [15:0] coolant_tenths;
    logic [15:0]        engine_off_timer;
    logic [15:0]        pump_timer;
    logic [3:0]         message_timer;
    logic               afterrun_started;
    logic               pump_level;
    logic               fan_level;
    logic               led_level;
    shift_phase_t       shift_phase;
    logic               shift_is_down;
    logic [4:0]         shift_timer;
  } state_t;

  typedef struct packed {
    logic pump_on;
    logic fan_on;
    logic fuel_enable;
    logic spark_enable;
    logic shift_up_drive;
    logic shift_down_drive;
    logic activity_led;
    logic status_send;
    logic status_neutral;
    logic status_fuel_flag;
  } result_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/eac_rules.sv
`default_nettype none

module eac_rules (
  input  wire eac_pkg::cfg_t    cfg,
  input  wire eac_pkg::state_t  state,
  input  wire eac_pkg::item_t   item,
  output eac_pkg::state_t  state_next,
  output eac_pkg::result_t result
);

  eac_pkg::state_t s;
  logic            fuel;
  logic            send;
  logic            fan_zone;

  always_comb begin
    s = state;

    // Apply the item itself
    if (item.action == eac_pkg::ACTION_FRAME) begin
      s.led_level = ~s.led_level;
      if (item.frame_id == eac_pkg::ID_RPM) begin
        s.engine_rpm       = {item.data_byte1, item.data_byte0};
        s.pump_timer       = 16'd0;
        s.engine_off_timer = 16'd0;
        s.afterrun_started = 1'b0;
        if (s.engine_rpm > cfg.pump_on_rpm) begin
          s.pump_level = 1'b1;
        end
      end
      if (item.frame_id == eac_pkg::ID_STEER && s.shift_phase == eac_pkg::PH_IDLE &&
          (item.data_byte0 == eac_pkg::CMD_UP || item.data_byte0 == eac_pkg::CMD_DOWN)) begin
        s.shift_phase   = eac_pkg::PH_CUT;
        s.shift_timer   = 5'd0;
        s.shift_is_down = (item.data_byte0 == eac_pkg::CMD_DOWN);
      end
      if (item.frame_id == eac_pkg::ID_TEMP) begin
        s.coolant_tenths = {item.data_byte5, item.data_byte4};
      end
    end else begin
      s.engine_off_timer = eac_pkg::sat_inc16(s.engine_off_timer);
      s.pump_timer       = eac_pkg::sat_inc16(s.pump_timer);
      if (s.message_timer < eac_pkg::MSG_TIMER_MAX) begin
        s.message_timer = s.message_timer + 4'd1;
      end
      case (s.shift_phase)
        eac_pkg::PH_CUT: begin
          s.shift_timer = s.shift_timer + 5'd1;
          if (s.shift_timer >= eac_pkg::SPARK_CUT_TICKS) begin
            s.shift_phase = eac_pkg::PH_HOLD;
            s.shift_timer = 5'd0;
          end
        end
        eac_pkg::PH_HOLD: begin
          s.shift_timer = s.shift_timer + 5'd1;
          if (s.shift_timer >= eac_pkg::SOLENOID_TICKS) begin
            s.shift_phase = eac_pkg::PH_IDLE;
            s.shift_timer = 5'd0;
          end
        end
        default: begin
          s.shift_phase = eac_pkg::PH_IDLE;
          s.shift_timer = 5'd0;
        end
      endcase
    end

    // Engine-off detection starts the pump after-run
    if (s.engine_off_timer >= cfg.engine_off_ms && s.pump_level && !s.afterrun_started) begin
      s.pump_level       = 1'b1;
      s.fan_level        = 1'b0;
      s.engine_rpm       = 16'd0;
      s.pump_timer       = 16'd0;
      s.afterrun_started = 1'b1;
    end
    if (s.pump_timer >= cfg.afterrun_ms) begin
      s.pump_level = 1'b0;
      s.pump_timer = 16'd0;
    end

    // Fan hysteresis, then the low-rpm override
    fan_zone = (s.engine_rpm > cfg.fan_min_rpm);
    if (fan_zone && s.coolant_tenths >= cfg.fan_on_temp) begin
      s.fan_level = 1'b1;
    end else if (fan_zone && s.coolant_tenths <= cfg.fan_off_temp) begin
      s.fan_level = 1'b0;
    end
    if (s.engine_rpm < cfg.fan_cut_rpm) begin
      s.fan_level = 1'b0;
    end

    fuel = !(s.engine_rpm > cfg.fuel_cut_rpm && !item.neutral_level);

    send = 1'b0;
    if (s.message_timer > eac_pkg::STATUS_PERIOD) begin
      s.message_timer = 4'd0;
      send            = 1'b1;
    end

    state_next = s;

    result.pump_on          = s.pump_level;
    result.fan_on           = s.fan_level;
    result.fuel_enable      = fuel;
    result.spark_enable     = !(s.shift_phase == eac_pkg::PH_CUT ||
                                s.shift_phase == eac_pkg::PH_HOLD);
    result.shift_up_drive   = (s.shift_phase == eac_pkg::PH_HOLD) && !s.shift_is_down;
    result.shift_down_drive = (s.shift_phase == eac_pkg::PH_HOLD) && s.shift_is_down;
    result.activity_led     = s.led_level;
    result.status_send      = send;
    result.status_neutral   = send & item.neutral_level;
    result.status_fuel_flag = send & fuel;
  end

endmodule

`default_nettype wire

FILE: hdl/engine_aux_controller_unit.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  ---------------------------------------------
// in        input      in_valid / in_ready  action, frame_id, data_byte0/1/4/5,
//                                           neutral_level
// out       output     out_valid/out_ready  pump_on, fan_on, fuel_enable, spark_enable,
//                                           shift_up/down_drive, activity_led, status_*
// cfg       input      cfg_write            cfg_index (3 bits), cfg_data (16 bits)
//
// One word in, one word out. The input word is captured in an input register
// at its accepting edge, then the rule logic updates the controller state and
// loads the result register once it is free. A new word is taken every cycle
// unless the output stalls; the single rule pass between the registers sets that rate.
// Reset (synchronous, rst high) restores the register defaults, clears the
// timers and shift sequencer, and sets the activity LED level.
// A stalled output holds the result register and, behind it, the input register.

module engine_aux_controller_unit (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [28:0] frame_id,
  input  wire logic [7:0]  data_byte0,
  input  wire logic [7:0]  data_byte1,
  input  wire logic [7:0]  data_byte4,
  input  wire logic [7:0]  data_byte5,
  input  wire logic        neutral_level,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             pump_on,
  output logic             fan_on,
  output logic             fuel_enable,
  output logic             spark_enable,
  output logic             shift_up_drive,
  output logic             shift_down_drive,
  output logic             activity_led,
  output logic             status_send,
  output logic             status_neutral,
  output logic             status_fuel_flag,

  input  wire logic                            cfg_write,
  input  wire logic [eac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0]                     cfg_data
);

  eac_pkg::cfg_t    cfg;
  eac_pkg::state_t  state;
  eac_pkg::state_t  state_next;
  eac_pkg::item_t   item;
  eac_pkg::result_t result;
  eac_pkg::result_t result_next;
  logic             item_valid;
  logic             advance;

  // Move the captured word into the result register when that register is free
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pump_on_rpm   <= 16'd1500;
      cfg.fan_on_temp   <= 16'sd1500;
      cfg.fan_off_temp  <= 16'sd1300;
      cfg.fan_min_rpm   <= 16'd2200;
      cfg.fan_cut_rpm   <= 16'd1000;
      cfg.fuel_cut_rpm  <= 16'd10500;
      cfg.engine_off_ms <= 16'd1500;
      cfg.afterrun_ms   <= 16'd13500;
    end else if (cfg_write) begin
      unique case (cfg_index)
        eac_pkg::CFG_PUMP_ON_RPM:   cfg.pump_on_rpm   <= cfg_data;
        eac_pkg::CFG_FAN_ON_TEMP:   cfg.fan_on_temp   <= cfg_data;
        eac_pkg::CFG_FAN_OFF_TEMP:  cfg.fan_off_temp  <= cfg_data;
        eac_pkg::CFG_FAN_MIN_RPM:   cfg.fan_min_rpm   <= cfg_data;
        eac_pkg::CFG_FAN_CUT_RPM:   cfg.fan_cut_rpm   <= cfg_data;
        eac_pkg::CFG_FUEL_CUT_RPM:  cfg.fuel_cut_rpm  <= cfg_data;
        eac_pkg::CFG_ENGINE_OFF_MS: cfg.engine_off_ms <= cfg_data;
        eac_pkg::CFG_AFTERRUN_MS:   cfg.afterrun_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: capture a word whenever the slot is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.action        <= action;
      item.frame_id      <= frame_id;
      item.data_byte0    <= data_byte0;
      item.data_byte1    <= data_byte1;
      item.data_byte4    <= data_byte4;
      item.data_byte5    <= data_byte5;
      item.neutral_level <= neutral_level;
    end
  end

  eac_rules u_rules (
    .cfg        (cfg),
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (result_next)
  );

  // Controller state: advance once per word, in order
  always_ff @(posedge clk) begin
    if (rst) begin
      state.engine_rpm       <= 16'd0;
      state.coolant_tenths   <= 16'sd0;
      state.engine_off_timer <= 16'd0;
      state.pump_timer       <= 16'd0;
      state.message_timer    <= 4'd0;
      state.afterrun_started <= 1'b0;
      state.pump_level       <= 1'b0;
      state.fan_level        <= 1'b0;
      state.led_level        <= 1'b1;
      state.shift_phase      <= eac_pkg::PH_IDLE;
      state.shift_is_down    <= 1'b0;
      state.shift_timer      <= 5'd0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign pump_on          = result.pump_on;
  assign fan_on           = result.fan_on;
  assign fuel_enable      = result.fuel_enable;
  assign spark_enable     = result.spark_enable;
  assign shift_up_drive   = result.shift_up_drive;
  assign shift_down_drive = result.shift_down_drive;
  assign activity_led     = result.activity_led;
  assign status_send      = result.status_send;
  assign status_neutral   = result.status_neutral;
  assign status_fuel_flag = result.status_fuel_flag;

`ifndef SYNTHESIS
  // The status counter is cleared as soon as it passes its period
  a_msg_timer_bound: assert property (@(posedge clk) disable iff (rst)
    state.message_timer <= eac_pkg::STATUS_PERIOD)
    else $error("message timer above status period");

  // A solenoid is only driven with spark cut, and never both at once
  a_solenoid_spark: assert property (@(posedge clk) disable iff (rst)
    out_valid && (shift_up_drive || shift_down_drive) |-> !spark_enable &&
      !(shift_up_drive && shift_down_drive))
    else $error("solenoid drive without spark cut");

  // Status payload bits are quiet when no status word goes out
  a_status_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status_send |-> !status_neutral && !status_fuel_flag)
    else $error("status bits set without status send");

  // The shift timer never runs past the solenoid hold time
  a_shift_timer_bound: assert property (@(posedge clk) disable iff (rst)
    state.shift_timer < eac_pkg::SOLENOID_TICKS)
    else $error("shift timer out of range");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  // Random phases, each with its own register settings
  localparam int PHASES          = 6;
  localparam int WORDS_PER_PHASE = 315;
  // Pipeline is two deep; give it spare cycles before touching registers
  localparam int SETTLE_CYCLES   = 6;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  // One directed word: payload, plus a hand-written expectation where it is obvious
  typedef struct {
    eac_pkg::item_t   w;
    bit               typed;
    eac_pkg::result_t want;
  } table_row_t;

  logic        clk;
  logic        rst           = 1'b1;

  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic        action        = 1'b0;
  logic [28:0] frame_id      = '0;
  logic [7:0]  data_byte0    = '0;
  logic [7:0]  data_byte1    = '0;
  logic [7:0]  data_byte4    = '0;
  logic [7:0]  data_byte5    = '0;
  logic        neutral_level = 1'b0;

  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic        pump_on;
  logic        fan_on;
  logic        fuel_enable;
  logic        spark_enable;
  logic        shift_up_drive;
  logic        shift_down_drive;
  logic        activity_led;
  logic        status_send;
  logic        status_neutral;
  logic        status_fuel_flag;

  logic                            cfg_write = 1'b0;
  logic [eac_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]                     cfg_data  = '0;

  engine_aux_controller_unit uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .frame_id         (frame_id),
    .data_byte0       (data_byte0),
    .data_byte1       (data_byte1),
    .data_byte4       (data_byte4),
    .data_byte5       (data_byte5),
    .neutral_level    (neutral_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .pump_on          (pump_on),
    .fan_on           (fan_on),
    .fuel_enable      (fuel_enable),
    .spark_enable     (spark_enable),
    .shift_up_drive   (shift_up_drive),
    .shift_down_drive (shift_down_drive),
    .activity_led     (activity_led),
    .status_send      (status_send),
    .status_neutral   (status_neutral),
    .status_fuel_flag (status_fuel_flag),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a word
  initial begin
    #400000;
    $display("timeout: drive words still outstanding or input never accepted");
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Controller model: settings and state mirrored from the block
  // ---------------------------------------------------------------------------
  eac_pkg::cfg_t         limits;
  logic [15:0]           rpm_now;
  logic signed [15:0]    coolant_now;
  logic [15:0]           stop_ms;         // ticks since the last rpm frame
  logic [15:0]           pump_ms;         // after-run timer
  logic [3:0]            status_ms;
  logic                  afterrun_on;
  logic                  pump_lvl;
  logic                  fan_lvl;
  logic                  led_lvl;
  eac_pkg::shift_phase_t phase_now;
  logic                  shift_down_sel;
  logic [4:0]            shift_ms;

  eac_pkg::result_t pending_drives[$];   // drive words still owed by the block
  table_row_t dir_rows[$];
  int burst_left  = 0;
  int fault_count = 0;
  int words_seen  = 0;

  // Apply one word to the model and return the drive levels it leaves behind
  function automatic eac_pkg::result_t compute_drives(input eac_pkg::item_t w);
    eac_pkg::result_t r;
    logic             fuel;
    logic             send;
    send = 1'b0;
    if (w.action == eac_pkg::ACTION_FRAME) begin
      led_lvl = ~led_lvl;
      if (w.frame_id == eac_pkg::ID_RPM) begin
        rpm_now     = {w.data_byte1, w.data_byte0};
        pump_ms     = '0;
        stop_ms     = '0;
        afterrun_on = 1'b0;
        if (rpm_now > limits.pump_on_rpm) pump_lvl = 1'b1;
      end
      // a shift request only starts from idle; anything else on the steering id drops
      if (w.frame_id == eac_pkg::ID_STEER && phase_now == eac_pkg::PH_IDLE &&
          (w.data_byte0 == eac_pkg::CMD_UP || w.data_byte0 == eac_pkg::CMD_DOWN)) begin
        phase_now      = eac_pkg::PH_CUT;
        shift_ms       = '0;
        shift_down_sel = (w.data_byte0 == eac_pkg::CMD_DOWN);
      end
      if (w.frame_id == eac_pkg::ID_TEMP) coolant_now = {w.data_byte5, w.data_byte4};
    end else begin
      // timers saturate instead of wrapping
      if (stop_ms != 16'hFFFF) stop_ms = stop_ms + 16'd1;
      if (pump_ms != 16'hFFFF) pump_ms = pump_ms + 16'd1;
      if (status_ms < eac_pkg::MSG_TIMER_MAX) status_ms = status_ms + 4'd1;
      case (phase_now)
        eac_pkg::PH_CUT: begin
          shift_ms = shift_ms + 5'd1;
          if (shift_ms >= eac_pkg::SPARK_CUT_TICKS) begin
            phase_now = eac_pkg::PH_HOLD;
            shift_ms  = '0;
          end
        end
        eac_pkg::PH_HOLD: begin
          shift_ms = shift_ms + 5'd1;
          if (shift_ms >= eac_pkg::SOLENOID_TICKS) begin
            phase_now = eac_pkg::PH_IDLE;
            shift_ms  = '0;
          end
        end
        default: begin
          phase_now = eac_pkg::PH_IDLE;
          shift_ms  = '0;
        end
      endcase
    end

    // engine stopped: keep the pump running and start the after-run
    if (stop_ms >= limits.engine_off_ms && pump_lvl && !afterrun_on) begin
      fan_lvl     = 1'b0;
      rpm_now     = '0;
      pump_ms     = '0;
      afterrun_on = 1'b1;
    end
    if (pump_ms >= limits.afterrun_ms) begin
      pump_lvl = 1'b0;
      pump_ms  = '0;
    end

    // fan hysteresis above the minimum rpm, forced off at low rpm
    if (rpm_now > limits.fan_min_rpm &&
        $signed(coolant_now) >= $signed(limits.fan_on_temp))
      fan_lvl = 1'b1;
    else if (rpm_now > limits.fan_min_rpm &&
             $signed(coolant_now) <= $signed(limits.fan_off_temp))
      fan_lvl = 1'b0;
    if (rpm_now < limits.fan_cut_rpm) fan_lvl = 1'b0;

    fuel = (rpm_now > limits.fuel_cut_rpm && w.neutral_level == 1'b0) ? 1'b0 : 1'b1;

    if (status_ms > eac_pkg::STATUS_PERIOD) begin
      status_ms = '0;
      send      = 1'b1;
    end

    r.pump_on          = pump_lvl;
    r.fan_on           = fan_lvl;
    r.fuel_enable      = fuel;
    r.spark_enable     = !(phase_now == eac_pkg::PH_CUT || phase_now == eac_pkg::PH_HOLD);
    r.shift_up_drive   = (phase_now == eac_pkg::PH_HOLD) && !shift_down_sel;
    r.shift_down_drive = (phase_now == eac_pkg::PH_HOLD) && shift_down_sel;
    r.activity_led     = led_lvl;
    r.status_send      = send;
    r.status_neutral   = send & w.neutral_level;
    r.status_fuel_flag = send & fuel;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of words with random gaps; valid holds until accepted
  // ---------------------------------------------------------------------------
  task automatic send_word(input eac_pkg::item_t w, input bit typed,
                           input eac_pkg::result_t want);
    int               gap;
    eac_pkg::result_t predicted;
    if (burst_left == 0) begin
      // mostly short bursts, now and then a long run with no gaps
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    action        <= w.action;
    frame_id      <= w.frame_id;
    data_byte0    <= w.data_byte0;
    data_byte1    <= w.data_byte1;
    data_byte4    <= w.data_byte4;
    data_byte5    <= w.data_byte5;
    neutral_level <= w.neutral_level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // word taken at this edge: advance the model and queue its drive word
    predicted = compute_drives(w);
    pending_drives.push_back(typed ? want : predicted);
  endtask

  task automatic add_row(input logic act, input logic [28:0] id,
                         input logic [7:0] b0, input logic [7:0] b1,
                         input logic [7:0] b4, input logic [7:0] b5,
                         input logic nl, input bit typed, input eac_pkg::result_t want);
    table_row_t row;
    row.w.action        = act;
    row.w.frame_id      = id;
    row.w.data_byte0    = b0;
    row.w.data_byte1    = b1;
    row.w.data_byte4    = b4;
    row.w.data_byte5    = b5;
    row.w.neutral_level = nl;
    row.typed           = typed;
    row.want            = want;
    dir_rows.push_back(row);
  endtask

  // Write one register; the model copy follows at the same edge
  task automatic write_reg(input logic [eac_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      eac_pkg::CFG_PUMP_ON_RPM:   limits.pump_on_rpm   = value;
      eac_pkg::CFG_FAN_ON_TEMP:   limits.fan_on_temp   = value;
      eac_pkg::CFG_FAN_OFF_TEMP:  limits.fan_off_temp  = value;
      eac_pkg::CFG_FAN_MIN_RPM:   limits.fan_min_rpm   = value;
      eac_pkg::CFG_FAN_CUT_RPM:   limits.fan_cut_rpm   = value;
      eac_pkg::CFG_FUEL_CUT_RPM:  limits.fuel_cut_rpm  = value;
      eac_pkg::CFG_ENGINE_OFF_MS: limits.engine_off_ms = value;
      eac_pkg::CFG_AFTERRUN_MS:   limits.afterrun_ms   = value;
      default: ;
    endcase
  endtask

  // Hold until every queued drive word has come back, then let the pipe empty
  task automatic wait_drained();
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a mode that changes every so often
  // ---------------------------------------------------------------------------
  rx_mode_t   rx_mode   = RX_OPEN;
  int         rx_left   = 0;
  logic [7:0] ready_pat = 8'h5B;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode   <= rx_mode_t'($urandom_range(0, 2));
      rx_left   <= $urandom_range(16, 200);
      ready_pat <= 8'($urandom_range(1, 255));
    end else begin
      rx_left   <= rx_left - 1;
      ready_pat <= {ready_pat[0], ready_pat[7:1]};
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      default:   out_ready <= ready_pat[0];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each accepted drive word against the oldest expectation
  // ---------------------------------------------------------------------------
  eac_pkg::result_t got_word;
  eac_pkg::result_t want_word;
  string            bad_fields;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_word = {pump_on, fan_on, fuel_enable, spark_enable, shift_up_drive,
                  shift_down_drive, activity_led, status_send, status_neutral,
                  status_fuel_flag};
      if (pending_drives.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("word %0d: drive word with nothing expected, got %b", words_seen, got_word);
      end else begin
        want_word  = pending_drives.pop_front();
        bad_fields = "";
        if (got_word.pump_on !== want_word.pump_on)
          bad_fields = {bad_fields, " pump_on"};
        if (got_word.fan_on !== want_word.fan_on)
          bad_fields = {bad_fields, " fan_on"};
        if (got_word.fuel_enable !== want_word.fuel_enable)
          bad_fields = {bad_fields, " fuel_enable"};
        if (got_word.spark_enable !== want_word.spark_enable)
          bad_fields = {bad_fields, " spark_enable"};
        if (got_word.shift_up_drive !== want_word.shift_up_drive)
          bad_fields = {bad_fields, " shift_up_drive"};
        if (got_word.shift_down_drive !== want_word.shift_down_drive)
          bad_fields = {bad_fields, " shift_down_drive"};
        if (got_word.activity_led !== want_word.activity_led)
          bad_fields = {bad_fields, " activity_led"};
        if (got_word.status_send !== want_word.status_send)
          bad_fields = {bad_fields, " status_send"};
        if (got_word.status_neutral !== want_word.status_neutral)
          bad_fields = {bad_fields, " status_neutral"};
        if (got_word.status_fuel_flag !== want_word.status_fuel_flag)
          bad_fields = {bad_fields, " status_fuel_flag"};
        if (bad_fields != "") begin
          fault_count++;
          if (fault_count <= 10)
            $display("word %0d: mismatch on%s (fields pump..fuel_flag) expected %b got %b",
                     words_seen, bad_fields, want_word, got_word);
        end
      end
      words_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    eac_pkg::item_t w;
    eac_pkg::cfg_t  plan;
    int             tick_run;
    int             kind;
    logic [15:0]    delta;

    // model starts from the reset defaults
    limits.pump_on_rpm   = 16'd1500;
    limits.fan_on_temp   = 16'd1500;
    limits.fan_off_temp  = 16'd1300;
    limits.fan_min_rpm   = 16'd2200;
    limits.fan_cut_rpm   = 16'd1000;
    limits.fuel_cut_rpm  = 16'd10500;
    limits.engine_off_ms = 16'd1500;
    limits.afterrun_ms   = 16'd13500;
    rpm_now        = '0;
    coolant_now    = '0;
    stop_ms        = '0;
    pump_ms        = '0;
    status_ms      = '0;
    afterrun_on    = 1'b0;
    pump_lvl       = 1'b0;
    fan_lvl        = 1'b0;
    led_lvl        = 1'b1;
    phase_now      = eac_pkg::PH_IDLE;
    shift_down_sel = 1'b0;
    shift_ms       = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset settings. Hand-typed drive bit order:
    // pump fan fuel spark up down led send status_neutral status_fuel_flag
    // unknown id with every bit set: only the LED toggles
    add_row(eac_pkg::ACTION_FRAME, 29'h1FFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
            1'b1, 10'b0_0_1_1_0_0_0_0_0_0);
    // tick with an all-zero payload that looks like a steering frame
    add_row(eac_pkg::ACTION_TICK, eac_pkg::ID_STEER, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
            1'b1, 10'b0_0_1_1_0_0_0_0_0_0);
    // top rpm, in gear: pump on, fuel cut
    add_row(eac_pkg::ACTION_FRAME, eac_pkg::ID_RPM, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0,
            1'b1, 10'b1_0_0_1_0_0_1_0_0_0);
    // same rpm in neutral: fuel back on
    add_row(eac_pkg::ACTION_FRAME, eac_pkg::ID_RPM, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1,
            1'b1, 10'b1_0_1_1_0_0_0_0_0_0);
    // hottest and coldest coolant readings
    add_row(eac_pkg::ACTION_FRAME, eac_pkg::ID_TEMP, 8'h00, 8'h00, 8'hFF, 8'h7F, 1'b1,
            1'b0, '0);
    add_row(eac_pkg::ACTION_FRAME, eac_pkg::ID_TEMP, 8'h00, 8'h00, 8'h00, 8'h80, 1'b0,
            1'b0, '0);
    // upshift, then a downshift request while busy that must be dropped
    add_row(eac_pkg::ACTION_FRAME, eac_pkg::ID_STEER, eac_pkg::CMD_UP, 8'h00, 8'h00,
            8'h00, 1'b1, 1'b0, '0);
    add_row(eac_pkg::ACTION_FRAME, eac_pkg::ID_STEER, eac_pkg::CMD_DOWN, 8'h00, 8'h00,
            8'h00, 1'b0, 1'b0, '0);
    // ten ticks: spark cut ends, solenoid starts, status pulse fires
    for (int i = 0; i < 10; i++)
      add_row(eac_pkg::ACTION_TICK, 29'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
    // steering byte that is neither command
    add_row(eac_pkg::ACTION_FRAME, eac_pkg::ID_STEER, 8'h0C, 8'h00, 8'h00, 8'h00, 1'b0,
            1'b0, '0);
    add_row(eac_pkg::ACTION_FRAME, eac_pkg::ID_STEER, eac_pkg::CMD_DOWN, 8'h00, 8'h00,
            8'h00, 1'b1, 1'b0, '0);
    // zero rpm forces the fan off
    add_row(eac_pkg::ACTION_FRAME, eac_pkg::ID_RPM, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
            1'b0, '0);
    // ids one off the known ones are just unknown frames
    add_row(eac_pkg::ACTION_FRAME, eac_pkg::ID_RPM + 29'd1, 8'h34, 8'h12, 8'h00, 8'h00,
            1'b0, 1'b0, '0);
    add_row(eac_pkg::ACTION_FRAME, eac_pkg::ID_TEMP - 29'd1, 8'h00, 8'h00, 8'hFF, 8'h7F,
            1'b1, 1'b0, '0);
    add_row(eac_pkg::ACTION_TICK, 29'h1FFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
            1'b0, '0);

    foreach (dir_rows[r])
      send_word(dir_rows[r].w, dir_rows[r].typed, dir_rows[r].want);
    in_valid <= 1'b0;
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      // realistic settings with short timers so after-run is reached often
      plan.pump_on_rpm   = 16'($urandom_range(0, 12000));
      plan.fan_on_temp   = 16'($urandom_range(0, 2500)) - 16'd500;
      plan.fan_off_temp  = plan.fan_on_temp - 16'($urandom_range(0, 400));
      plan.fan_min_rpm   = 16'($urandom_range(0, 8000));
      plan.fan_cut_rpm   = 16'($urandom_range(0, plan.fan_min_rpm));
      plan.fuel_cut_rpm  = 16'($urandom_range(0, 15000));
      plan.engine_off_ms = 16'($urandom_range(0, 30));
      plan.afterrun_ms   = 16'($urandom_range(0, 60));
      if (p == 0) begin
        // lowest values everywhere
        plan.pump_on_rpm   = 16'h0000;
        plan.fan_on_temp   = 16'h8000;
        plan.fan_off_temp  = 16'h8000;
        plan.fan_min_rpm   = 16'h0000;
        plan.fan_cut_rpm   = 16'h0000;
        plan.fuel_cut_rpm  = 16'h0000;
        plan.engine_off_ms = 16'h0000;
        plan.afterrun_ms   = 16'h0000;
      end else if (p == 1) begin
        // highest values everywhere
        plan.pump_on_rpm   = 16'hFFFF;
        plan.fan_on_temp   = 16'h7FFF;
        plan.fan_off_temp  = 16'h7FFF;
        plan.fan_min_rpm   = 16'hFFFF;
        plan.fan_cut_rpm   = 16'hFFFF;
        plan.fuel_cut_rpm  = 16'hFFFF;
        plan.engine_off_ms = 16'hFFFF;
        plan.afterrun_ms   = 16'hFFFF;
      end else if (p == 2) begin
        // inverted hysteresis: on-threshold at the bottom, off-threshold at the top
        plan.fan_on_temp  = 16'h8000;
        plan.fan_off_temp = 16'h7FFF;
      end
      write_reg(eac_pkg::CFG_PUMP_ON_RPM,   plan.pump_on_rpm);
      write_reg(eac_pkg::CFG_FAN_ON_TEMP,   plan.fan_on_temp);
      write_reg(eac_pkg::CFG_FAN_OFF_TEMP,  plan.fan_off_temp);
      write_reg(eac_pkg::CFG_FAN_MIN_RPM,   plan.fan_min_rpm);
      write_reg(eac_pkg::CFG_FAN_CUT_RPM,   plan.fan_cut_rpm);
      write_reg(eac_pkg::CFG_FUEL_CUT_RPM,  plan.fuel_cut_rpm);
      write_reg(eac_pkg::CFG_ENGINE_OFF_MS, plan.engine_off_ms);
      write_reg(eac_pkg::CFG_AFTERRUN_MS,   plan.afterrun_ms);
      cfg_write <= 1'b0;

      tick_run = 0;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // random payload everywhere, then shape it into a meaningful frame
        w.action        = eac_pkg::ACTION_FRAME;
        w.frame_id      = 29'($urandom);
        w.data_byte0    = 8'($urandom);
        w.data_byte1    = 8'($urandom);
        w.data_byte4    = 8'($urandom);
        w.data_byte5    = 8'($urandom);
        w.neutral_level = 1'($urandom);
        // now and then a long run of ticks so engine-off and after-run expire
        if (tick_run == 0 && $urandom_range(0, 99) < 3) tick_run = $urandom_range(5, 70);
        kind  = $urandom_range(0, 99);
        delta = 16'($urandom_range(0, 4)) - 16'd2;
        if (tick_run > 0 || kind < 45) begin
          w.action = eac_pkg::ACTION_TICK;
          if (tick_run > 0) tick_run--;
        end else if (kind < 62) begin
          // rpm on or next to one of the thresholds
          w.frame_id = eac_pkg::ID_RPM;
          case ($urandom_range(0, 5))
            0: ;
            1: {w.data_byte1, w.data_byte0} = limits.pump_on_rpm + delta;
            2: {w.data_byte1, w.data_byte0} = limits.fan_min_rpm + delta;
            3: {w.data_byte1, w.data_byte0} = limits.fan_cut_rpm + delta;
            4: {w.data_byte1, w.data_byte0} = limits.fuel_cut_rpm + delta;
            default: {w.data_byte1, w.data_byte0} =
                       ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
          endcase
        end else if (kind < 74) begin
          // coolant around the fan thresholds or at the signed extremes
          w.frame_id = eac_pkg::ID_TEMP;
          case ($urandom_range(0, 3))
            0: ;
            1: {w.data_byte5, w.data_byte4} = limits.fan_on_temp + delta;
            2: {w.data_byte5, w.data_byte4} = limits.fan_off_temp + delta;
            default: {w.data_byte5, w.data_byte4} =
                       ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
          endcase
        end else if (kind < 88) begin
          // mostly real shift commands, some junk steering bytes
          w.frame_id = eac_pkg::ID_STEER;
          if ($urandom_range(0, 7) != 0)
            w.data_byte0 = ($urandom_range(0, 1) != 0) ? eac_pkg::CMD_UP
                                                      : eac_pkg::CMD_DOWN;
        end else if (kind < 94) begin
          // known id with one bit flipped
          case ($urandom_range(0, 2))
            0:       w.frame_id = eac_pkg::ID_RPM;
            1:       w.frame_id = eac_pkg::ID_TEMP;
            default: w.frame_id = eac_pkg::ID_STEER;
          endcase
          w.frame_id = w.frame_id ^ (29'd1 << $urandom_range(0, 28));
        end
        send_word(w, 1'b0, '0);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
